@@ src/bmsrfd_pkg.sv @@
// Package for the battery-management response frame decoder.
// Holds frame constants, register indexes and query kind codes.
// No dependencies; the top level imports it.
package bmsrfd_pkg;

  localparam int FrameBytes   = 13;
  localparam int PayloadFirst = 4;
  localparam int PayloadDepth = 8;

  localparam logic [3:0] LastIdx  = 4'(FrameBytes - 1);
  localparam logic [3:0] FirstIdx = 4'(PayloadFirst);

  localparam logic [15:0] CurrentOffsetReset = 16'd3000;
  localparam logic [7:0]  TempOffsetReset    = 8'd40;

  typedef enum logic [0:0] {
    CFG_CURRENT_OFFSET = 1'b0,
    CFG_TEMP_OFFSET    = 1'b1
  } cfg_index_t;

  localparam logic [2:0] KIND_POWER  = 3'd0;
  localparam logic [2:0] KIND_STATUS = 3'd1;
  localparam logic [2:0] KIND_CELLS  = 3'd2;
  localparam logic [2:0] KIND_TEMP   = 3'd3;
  localparam logic [2:0] KIND_FAULT  = 3'd4;

endpackage

@@ src/bmsrfd_if.sv @@
// Request channel interfaces of the frame decoder: received bytes in, results out.
// Depends on nothing beyond the language; widths follow the frame fields.
interface bmsrfd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic [2:0] req_type;

  modport source (output valid, output rx_byte, output req_type, input ready);
  modport sink   (input valid, input rx_byte, input req_type, output ready);
endinterface

interface bmsrfd_res_if;
  logic               valid;
  logic               ready;
  logic               checksum_ok;
  logic [2:0]         frame_kind;
  logic signed [32:0] power;
  logic [15:0]        charge_level;
  logic               charging;
  logic [31:0]        remaining_capacity;
  logic [7:0]         cell_count;
  logic signed [9:0]  temp_half_deg;
  logic               fault;

  modport source (output valid, output checksum_ok, output frame_kind, output power,
                  output charge_level, output charging, output remaining_capacity,
                  output cell_count, output temp_half_deg, output fault, input ready);
  modport sink   (input valid, input checksum_ok, input frame_kind, input power,
                  input charge_level, input charging, input remaining_capacity,
                  input cell_count, input temp_half_deg, input fault, output ready);
endinterface

@@ src/bms_response_frame_decoder.sv @@
// Top level of the battery-management response frame decoder.
// Depends on bmsrfd_pkg and the channel interfaces in bmsrfd_if.sv.
//
// The rx channel takes one received byte per request, tagged with the query
// kind outstanding; the kind is latched on the first byte of each 13-byte frame.
// Bytes are counted, summed modulo 256, and the payload bytes 4 to 11 are kept
// in registers. When byte 12 is accepted, the checksum flag and the fields of
// the latched kind are computed and loaded into the result register, so the
// result request appears on the res channel in the next cycle. Fields that do
// not belong to the kind read as zero.
// One byte is accepted every cycle unless the result register stalls; bytes 0 to 11 produce no result. The only
// wait comes from the result register: while a result is held and res.ready
// is low, rx.ready is low as well, and nothing is lost or repeated.
// Configuration writes on cfg_we take effect at the next edge and should be
// made between frames. Reset clears the byte counter, the sum, the latched
// kind and the result valid, and restores the current offset to 3000 and the
// temperature offset to 40.
module bms_response_frame_decoder
  import bmsrfd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  cfg_index_t   cfg_index,
  input  logic [15:0]  cfg_data,
  bmsrfd_rx_if.sink    rx,
  bmsrfd_res_if.source res
);

  logic [15:0] current_offset;
  logic [7:0]  temp_offset;
  logic [3:0]  byte_index;
  logic [7:0]  running_sum;
  logic [2:0]  latched_kind;
  logic [7:0]  payload_bytes [PayloadDepth];
  logic        res_valid;

  logic               rx_fire;
  logic               last_byte;
  logic [7:0]         sum_base;
  logic [2:0]         kind_now;
  logic [2:0]         store_idx;
  logic [16:0]        cur_diff;
  logic signed [33:0] product;
  logic [9:0]         temp_sum;
  logic               any_fault;

  logic               checksum_ok_next;
  logic signed [32:0] power_next;
  logic [15:0]        charge_level_next;
  logic               charging_next;
  logic [31:0]        remaining_capacity_next;
  logic [7:0]         cell_count_next;
  logic signed [9:0]  temp_half_deg_next;
  logic               fault_next;

  assign rx.ready  = !res_valid || res.ready;
  assign rx_fire   = rx.valid && rx.ready;
  assign last_byte = (byte_index == LastIdx);
  assign sum_base  = (byte_index == 4'd0) ? 8'd0 : running_sum;
  assign kind_now  = (byte_index == 4'd0) ? rx.req_type : latched_kind;
  assign store_idx = 3'(byte_index - FirstIdx);

  // Payload slot k holds frame byte k + 4.
  assign cur_diff = {1'b0, payload_bytes[4], payload_bytes[5]} - {1'b0, current_offset};
  assign product  = $signed({1'b0, payload_bytes[2], payload_bytes[3]}) * $signed(cur_diff);
  assign temp_sum = ({2'b00, payload_bytes[1]} - {2'b00, temp_offset})
                  + ({2'b00, payload_bytes[2]} - {2'b00, temp_offset});
  assign any_fault = |{payload_bytes[1], payload_bytes[2], payload_bytes[3], payload_bytes[4],
                       payload_bytes[5], payload_bytes[6], payload_bytes[7]};

  always_comb begin
    checksum_ok_next        = (running_sum == rx.rx_byte);
    power_next              = '0;
    charge_level_next       = '0;
    charging_next           = 1'b0;
    remaining_capacity_next = '0;
    cell_count_next         = '0;
    temp_half_deg_next      = '0;
    fault_next              = 1'b0;
    unique case (latched_kind)
      KIND_POWER: begin
        power_next        = product[32:0];
        charge_level_next = {payload_bytes[6], payload_bytes[7]};
      end
      KIND_STATUS: begin
        charging_next           = (payload_bytes[0] == 8'd1);
        remaining_capacity_next = {payload_bytes[1], payload_bytes[2],
                                   payload_bytes[3], payload_bytes[4]};
      end
      KIND_CELLS: begin
        cell_count_next = payload_bytes[0];
      end
      KIND_TEMP: begin
        temp_half_deg_next = $signed(temp_sum);
      end
      KIND_FAULT: begin
        fault_next = any_fault;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_offset <= CurrentOffsetReset;
      temp_offset    <= TempOffsetReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CURRENT_OFFSET: current_offset <= cfg_data;
        CFG_TEMP_OFFSET:    temp_offset    <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index   <= '0;
      running_sum  <= '0;
      latched_kind <= '0;
    end else if (rx_fire) begin
      latched_kind <= kind_now;
      if (last_byte) begin
        byte_index  <= '0;
        running_sum <= '0;
      end else begin
        byte_index  <= byte_index + 4'd1;
        running_sum <= sum_base + rx.rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rx_fire && byte_index >= FirstIdx && byte_index < LastIdx) begin
      payload_bytes[store_idx] <= rx.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (rx_fire && last_byte) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_fire && last_byte) begin
      res.checksum_ok        <= checksum_ok_next;
      res.frame_kind         <= latched_kind;
      res.power              <= power_next;
      res.charge_level       <= charge_level_next;
      res.charging           <= charging_next;
      res.remaining_capacity <= remaining_capacity_next;
      res.cell_count         <= cell_count_next;
      res.temp_half_deg      <= temp_half_deg_next;
      res.fault              <= fault_next;
    end
  end

  assign res.valid = res_valid;

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    byte_index <= LastIdx)
    else $error("byte counter ran past the last frame byte");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    rx_fire && last_byte |=> res.valid)
    else $error("no result after the last frame byte");

  a_stall_blocks_rx: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.ready |-> !rx.ready)
    else $error("byte accepted while a result is stalled");

  a_first_byte_counts: assert property (@(posedge clk) disable iff (rst)
    rx_fire && byte_index == 4'd0 |=> byte_index == 4'd1 && latched_kind == $past(rx.req_type))
    else $error("first frame byte not counted or kind not latched");

endmodule
